### design/bsm_pkg.sv
// Shared types and constants for the byte stack machine.
package bsm_pkg;

  localparam logic [7:0] OP_HALT = 8'd0;
  localparam logic [7:0] OP_PUSH = 8'd1;
  localparam logic [7:0] OP_POP  = 8'd2;
  localparam logic [7:0] OP_ADD  = 8'd3;
  localparam logic [7:0] OP_SUB  = 8'd4;
  localparam logic [7:0] OP_MUL  = 8'd5;
  localparam logic [7:0] OP_DIV  = 8'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_POPPED    = 3'd1;
  localparam logic [2:0] ST_HALTED    = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;
  localparam logic [2:0] ST_DIVZERO   = 3'd5;
  localparam logic [2:0] ST_UNKNOWN   = 3'd6;
  localparam logic [2:0] ST_STOPPED   = 3'd7;

  typedef struct packed {
    logic [7:0] action;
    logic [7:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] result_value;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // capture the input beat
    logic       rd_en;     // stack read, data registered
    logic       rd_next;   // 0: top entry, 1: entry below top
    logic       lat_a;
    logic       lat_b;
    logic       wr_en;
    logic       wr_res;    // 0: push operand at count, 1: result at count-2
    logic       cnt_up;
    logic       cnt_dn;
    logic       set_stop;
    logic       alu_go;
    logic       div_go;
    logic       div_take;
    logic       out_load;
    logic [2:0] out_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [7:0] op;
    logic       stopped;
    logic       cnt_zero;
    logic       cnt_lt2;
    logic       cnt_full;
    logic       b_zero;
    logic       div_done;
    logic       out_free;
  } stat_t;

endpackage

### design/byte_stack_machine_core.sv
// Byte stack machine: one instruction per input beat, one result beat per instruction.
// Halt/push/overflow/underflow/unknown/stopped: decode, done; pop: decode, read, done.
// Add/sub/mul: decode, two reads, execute, write, done; div waits for the 8-step
// divider before write, and divide by zero ends after execute. One at a time: the
// next beat is taken in the cycle after the result loads; out stalls delay it.
// Reset clears stack pointer, stopped flag and control; stack memory is not cleared.
module byte_stack_machine_core #(
  parameter int STACK_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bsm_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bsm_pkg::out_item_t out_data_o
);

  bsm_pkg::cmd_t  cmd;
  bsm_pkg::stat_t stat;

  bsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bsm_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### design/bsm_div.sv
// Iterative 8-bit restoring divider, one quotient bit per cycle.
module bsm_div (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] dividend_i,
  input  logic [7:0] divisor_i,
  output logic       done_o,
  output logic [7:0] quotient_o
);

  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] quo_q, quo_d;
  logic [7:0] dvs_q, dvs_d;
  logic [8:0] trial;
  logic [8:0] diff;

  assign trial = {rem_q, quo_q[7]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      rem_d  = 8'd0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[8]) begin
        rem_d = diff[7:0];
        quo_d = {quo_q[6:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        quo_d = {quo_q[6:0], 1'b0};
      end
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### design/bsm_dp.sv
// Datapath: stack memory, stack pointer, operand registers, ALU, divider, output register.
module bsm_dp #(
  parameter int STACK_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsm_pkg::in_item_t in_data_i,
  input  bsm_pkg::cmd_t     cmd_i,
  output bsm_pkg::stat_t    stat_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bsm_pkg::out_item_t out_data_o
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic [7:0]    mem [STACK_DEPTH];
  logic [AW-1:0] cnt_q, cnt_d;
  logic          stop_q, stop_d;
  logic          out_valid_q, out_valid_d;
  bsm_pkg::out_item_t out_q;

  logic [7:0]    op_q, operand_q;
  logic [7:0]    a_q, b_q, r_q, rdata_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data;
  logic [15:0]   prod;
  logic [7:0]    alu_res;
  logic          div_done;
  logic [7:0]    quotient;

  assign rd_addr = cmd_i.rd_next ? (cnt_q - AW'(2)) : (cnt_q - AW'(1));
  assign wr_addr = cmd_i.wr_res ? (cnt_q - AW'(2)) : cnt_q;
  assign wr_data = cmd_i.wr_res ? r_q : operand_q;

  assign prod = a_q * b_q;

  always_comb begin
    case (op_q)
      bsm_pkg::OP_ADD: alu_res = a_q + b_q;
      bsm_pkg::OP_SUB: alu_res = a_q - b_q;
      default:         alu_res = prod[7:0];
    endcase
  end

  bsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_up) begin
      cnt_d = cnt_q + AW'(1);
    end else if (cmd_i.cnt_dn) begin
      cnt_d = cnt_q - AW'(1);
    end
    stop_d = stop_q | cmd_i.set_stop;
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= in_data_i.action;
      operand_q <= in_data_i.operand_value;
    end
    if (cmd_i.lat_a) begin
      a_q <= rdata_q;
    end
    if (cmd_i.lat_b) begin
      b_q <= rdata_q;
    end
    if (cmd_i.div_take) begin
      r_q <= quotient;
    end else if (cmd_i.alu_go) begin
      r_q <= alu_res;
    end
    if (cmd_i.out_load) begin
      out_q.status       <= cmd_i.out_status;
      out_q.result_value <= (cmd_i.out_status == bsm_pkg::ST_POPPED) ? rdata_q : 8'd0;
    end
  end

  assign stat_o.op       = op_q;
  assign stat_o.stopped  = stop_q;
  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.cnt_lt2  = (cnt_q < AW'(2));
  assign stat_o.cnt_full = (cnt_q == AW'(STACK_DEPTH - 1));
  assign stat_o.b_zero   = (b_q == 8'd0);
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/bsm_ctrl.sv
// Controller: sequences decode, stack reads, execute and write-back for one instruction.
module bsm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bsm_pkg::stat_t stat_i,
  output bsm_pkg::cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_POP    = 9'b000000100,
    S_BIN_A  = 9'b000001000,
    S_BIN_B  = 9'b000010000,
    S_EXEC   = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_WRITE  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] pend_q, pend_d;

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    cmd_o.out_status = pend_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        if (stat_i.stopped) begin
          pend_d = bsm_pkg::ST_STOPPED;
        end else begin
          case (stat_i.op)
            bsm_pkg::OP_HALT: begin
              cmd_o.set_stop = 1'b1;
              pend_d = bsm_pkg::ST_HALTED;
            end
            bsm_pkg::OP_PUSH: begin
              if (stat_i.cnt_full) begin
                cmd_o.set_stop = 1'b1;
                pend_d = bsm_pkg::ST_OVERFLOW;
              end else begin
                cmd_o.wr_en  = 1'b1;
                cmd_o.cnt_up = 1'b1;
                pend_d = bsm_pkg::ST_OK;
              end
            end
            bsm_pkg::OP_POP: begin
              if (stat_i.cnt_zero) begin
                cmd_o.set_stop = 1'b1;
                pend_d = bsm_pkg::ST_UNDERFLOW;
              end else begin
                cmd_o.rd_en  = 1'b1;
                cmd_o.cnt_dn = 1'b1;
                pend_d  = bsm_pkg::ST_POPPED;
                state_d = S_POP;
              end
            end
            bsm_pkg::OP_ADD, bsm_pkg::OP_SUB, bsm_pkg::OP_MUL, bsm_pkg::OP_DIV: begin
              if (stat_i.cnt_lt2) begin
                cmd_o.set_stop = 1'b1;
                pend_d = bsm_pkg::ST_UNDERFLOW;
              end else begin
                cmd_o.rd_en = 1'b1;
                state_d = S_BIN_A;
              end
            end
            default: begin
              cmd_o.set_stop = 1'b1;
              pend_d = bsm_pkg::ST_UNKNOWN;
            end
          endcase
        end
      end
      S_POP: begin
        // read data lands this cycle
        state_d = S_DONE;
      end
      S_BIN_A: begin
        cmd_o.lat_a   = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d = S_BIN_B;
      end
      S_BIN_B: begin
        cmd_o.lat_b = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.op == bsm_pkg::OP_DIV) begin
          if (stat_i.b_zero) begin
            cmd_o.set_stop = 1'b1;
            pend_d  = bsm_pkg::ST_DIVZERO;
            state_d = S_DONE;
          end else begin
            cmd_o.div_go = 1'b1;
            state_d = S_DIV;
          end
        end else begin
          cmd_o.alu_go = 1'b1;
          state_d = S_WRITE;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        // two popped, one pushed: net count minus one
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_res = 1'b1;
        cmd_o.cnt_dn = 1'b1;
        pend_d  = bsm_pkg::ST_OK;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= bsm_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

### tb/testbench.sv
// Self-checking testbench for byte_stack_machine_core: instruction sequences against a mirror.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bsm_pkg::*;

  localparam int SLOTS = 256;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_CYCLES = 500000;
  localparam int SETTLE_CYCLES = 20;

  typedef enum int {
    END_HALT,
    END_OVERFLOW,
    END_UNDERFLOW,
    END_DIVZERO,
    END_UNKNOWN
  } stop_kind_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // mirror of the machine state
  logic [7:0] stk_m [SLOTS];
  int         sp_m = 0;
  bit         stopped_m = 1'b0;

  out_item_t  pending_results[$];
  out_item_t  want;
  int         err_cnt = 0;
  int         cycle_cnt = 0;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;
  int         hold_left = 0;

  byte_stack_machine_core #(
    .STACK_DEPTH(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stall, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 31);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d value %0d",
               out_data_o.status, out_data_o.result_value);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_data_o.status);
          err_cnt++;
        end
        if (out_data_o.result_value !== want.result_value) begin
          $error("result_value mismatch: expected %0d, got %0d",
                 want.result_value, out_data_o.result_value);
          err_cnt++;
        end
      end
    end
  end

  function automatic out_item_t execute_instr(in_item_t ins);
    out_item_t  res;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r;
    res.status = ST_OK;
    res.result_value = '0;
    if (stopped_m) begin
      res.status = ST_STOPPED;
      return res;
    end
    case (ins.action)
      OP_HALT: begin
        stopped_m = 1'b1;
        res.status = ST_HALTED;
      end
      OP_PUSH: begin
        if (sp_m + 1 >= SLOTS) begin
          stopped_m = 1'b1;
          res.status = ST_OVERFLOW;
        end else begin
          stk_m[sp_m] = ins.operand_value;
          sp_m++;
        end
      end
      OP_POP: begin
        if (sp_m == 0) begin
          stopped_m = 1'b1;
          res.status = ST_UNDERFLOW;
        end else begin
          sp_m--;
          res.status = ST_POPPED;
          res.result_value = stk_m[sp_m];
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (sp_m < 2) begin
          stopped_m = 1'b1;
          res.status = ST_UNDERFLOW;
        end else begin
          a = stk_m[sp_m - 1];
          b = stk_m[sp_m - 2];
          sp_m -= 2;
          if (ins.action == OP_DIV && b == 8'h00) begin
            stopped_m = 1'b1;
            res.status = ST_DIVZERO;
          end else begin
            if (ins.action == OP_ADD) r = a + b;
            else if (ins.action == OP_SUB) r = a - b;
            else if (ins.action == OP_MUL) r = a * b;
            else r = a / b;
            stk_m[sp_m] = r;
            sp_m++;
          end
        end
      end
      default: begin
        stopped_m = 1'b1;
        res.status = ST_UNKNOWN;
      end
    endcase
    return res;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_instr(input logic [7:0] act, input logic [7:0] opnd);
    in_item_t ins;
    ins.action = act;
    ins.operand_value = opnd;
    if (!calm) begin
      while ($urandom_range(99) < 31) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= ins;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(execute_instr(ins));
  endtask

  // drop valid so the last beat is not taken twice
  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    idle_input();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // legal instruction only; push_pct steers the stack depth
  task automatic random_instr(input int push_pct);
    int         r;
    logic [7:0] op;
    r = $urandom_range(99);
    if (sp_m == 0 || (r < push_pct && sp_m < SLOTS - 1)) begin
      send_instr(OP_PUSH, rand_byte());
    end else if (sp_m < 2 || r < push_pct + 15) begin
      send_instr(OP_POP, rand_byte());
    end else begin
      case ($urandom_range(3))
        0: op = OP_ADD;
        1: op = OP_SUB;
        2: op = OP_MUL;
        default: op = OP_DIV;
      endcase
      if (op == OP_DIV && stk_m[sp_m - 2] == 8'h00) op = OP_SUB;
      send_instr(op, rand_byte());
    end
  endtask

  task automatic test_directed_ops();
    send_instr(OP_PUSH, 8'h00);
    send_instr(OP_PUSH, 8'hFF);
    send_instr(OP_ADD, 8'hFF);
    send_instr(OP_POP, 8'h00);
    send_instr(OP_PUSH, 8'hFF);
    send_instr(OP_PUSH, 8'hFF);
    send_instr(OP_MUL, 8'h00);
    send_instr(OP_PUSH, 8'd7);
    send_instr(OP_PUSH, 8'd5);
    send_instr(OP_SUB, 8'hFF);   // wraps below zero
    send_instr(OP_DIV, 8'h00);
    send_instr(OP_PUSH, 8'h00);
    send_instr(OP_DIV, 8'hFF);   // zero dividend
    send_instr(OP_PUSH, 8'd3);
    send_instr(OP_PUSH, 8'd200);
    send_instr(OP_DIV, 8'hAA);
    send_instr(OP_PUSH, 8'hFF);
    send_instr(OP_PUSH, 8'hFF);
    send_instr(OP_ADD, 8'h55);
    send_instr(OP_POP, 8'hFF);
    send_instr(OP_POP, 8'h00);
    send_instr(OP_POP, 8'hFF);
  endtask

  task automatic test_back_to_back();
    idle_input();
    calm = 1'b1;
    repeat (150) random_instr(50);
    idle_input();
    calm = 1'b0;
  endtask

  task automatic test_random_programs();
    int push_pct;
    repeat (12) begin
      push_pct = $urandom_range(25, 75);
      repeat (100) random_instr(push_pct);
    end
  endtask

  task automatic test_drain_pause();
    repeat (20) random_instr(50);
    drain_results();
    repeat (20) random_instr(50);
  endtask

  task automatic test_full_stack();
    while (sp_m < SLOTS - 1) send_instr(OP_PUSH, rand_byte());
    send_instr(OP_POP, rand_byte());
    send_instr(OP_PUSH, rand_byte());
    send_instr(OP_ADD, rand_byte());
    send_instr(OP_PUSH, rand_byte());
    while (sp_m > 8) random_instr(15);
  endtask

  task automatic test_output_backpressure();
    idle_input();
    @(posedge clk_i);
    hold_req = 1'b1;
    repeat (30) random_instr(50);
  endtask

  // only one stop is observable per reset, so the kind is left to the seed
  task automatic test_terminal_error();
    stop_kind_e kind;
    int         target;
    logic [7:0] op;
    kind = stop_kind_e'($urandom_range(4));
    case (kind)
      END_HALT: send_instr(OP_HALT, rand_byte());
      END_OVERFLOW: begin
        while (sp_m < SLOTS - 1) send_instr(OP_PUSH, rand_byte());
        send_instr(OP_PUSH, rand_byte());
      end
      END_UNDERFLOW: begin
        target = $urandom_range(1);
        while (sp_m > target) send_instr(OP_POP, rand_byte());
        case ($urandom_range(4))
          0: op = OP_POP;
          1: op = OP_ADD;
          2: op = OP_SUB;
          3: op = OP_MUL;
          default: op = OP_DIV;
        endcase
        if (sp_m == 1 && op == OP_POP) op = OP_ADD;
        send_instr(op, rand_byte());
      end
      END_DIVZERO: begin
        send_instr(OP_PUSH, 8'h00);
        send_instr(OP_PUSH, rand_byte());
        send_instr(OP_DIV, rand_byte());
      end
      default: send_instr(8'($urandom_range(7, 255)), rand_byte());
    endcase
    repeat (20) send_instr(8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_ops();
    test_back_to_back();
    test_random_programs();
    test_drain_pause();
    test_full_stack();
    test_output_backpressure();
    test_terminal_error();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
design/bsm_pkg.sv
design/bsm_div.sv
design/bsm_dp.sv
design/bsm_ctrl.sv
design/byte_stack_machine_core.sv
tb/testbench.sv
